/* rtl/refcounted_page_allocator_top_macros.svh */
// Assertion macros for the refcounted page allocator.
// Included by the modules that carry concurrent assertions; needs nothing else.
`ifndef REFCOUNTED_PAGE_ALLOCATOR_TOP_MACROS_SVH
`define REFCOUNTED_PAGE_ALLOCATOR_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RPA_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RPA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/rpa_pkg.sv */
// Shared types, codes and sizes of the refcounted page allocator.
// Used by all modules but rpa_ram; depends on nothing.
package rpa_pkg;

   localparam int ADDR_BITS = 32;
   localparam int PAGE_SHIFT = 12;
   localparam int PN_BITS = ADDR_BITS - PAGE_SHIFT;
   localparam int CNT_BITS = 8;
   localparam int FREE_BITS = 16;
   localparam int NUM_PAGES_DEFAULT = 32768;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [CNT_BITS-1:0] CNT_MAX = 8'hFF;
   localparam logic [CNT_BITS-1:0] CNT_ONE = 8'h01;

   localparam logic [1:0] ACT_ALLOC = 2'd0;
   localparam logic [1:0] ACT_FREE = 2'd1;
   localparam logic [1:0] ACT_ADD_REF = 2'd2;
   localparam logic [1:0] ACT_QUERY = 2'd3;

   localparam logic [1:0] STAT_OK = 2'd0;
   localparam logic [1:0] STAT_NO_FREE = 2'd1;
   localparam logic [1:0] STAT_BAD_ADDR = 2'd2;
   localparam logic [1:0] STAT_STACK_FULL = 2'd3;

   localparam logic CSR_KERNEL_END = 1'b0;
   localparam logic CSR_PHYS_TOP = 1'b1;

   typedef struct packed {
      logic [1:0] action;
      logic [ADDR_BITS-1:0] page_addr;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [ADDR_BITS-1:0] alloc_addr;
      logic [CNT_BITS-1:0] ref_count;
      logic [FREE_BITS-1:0] free_pages;
   } rsp_type;

   typedef struct packed {
      logic [1:0] action;
      logic bad;
      logic [PN_BITS-1:0] pn;
      logic [PN_BITS-1:0] idx;
   } job_type;

endpackage

/* rtl/refcounted_page_allocator_top.sv */
// Top level of the refcounted page allocator: front end, job queue and back end.
// Depends on rpa_pkg, rpa_front, rpa_queue and rpa_back.
//
//   Channel  Direction  Handshake            Payload
//   req      in         req_valid/req_stall  rpa_pkg::req_type (action, page_addr)
//   rsp      out        rsp_valid/rsp_stall  rpa_pkg::rsp_type (status, alloc_addr, ...)
//   csr      in         csr_valid/csr_ready  csr_index, csr_wdata
//
// The back end reads the count table and the free stack in its idle state, and in its
// execute state writes them back and loads the result register.
// The front end registers the address check and the table index in its stages a and b,
// and the queue holds each job until the back end takes it.
// After reset a clearing pass writes every count to zero with req_stall held high;
// configuration writes are taken throughout. A stalled result register holds the back end;
// the queue lets the front keep accepting until it is full.
module refcounted_page_allocator_top #(
   parameter int NUM_PAGES = rpa_pkg::NUM_PAGES_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  rpa_pkg::req_type req_data,
   output logic rsp_valid,
   input  logic rsp_stall,
   output rpa_pkg::rsp_type rsp_data,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic csr_index,
   input  logic [rpa_pkg::ADDR_BITS-1:0] csr_wdata
);

   logic clearing;
   logic front_valid;
   logic front_ready;
   rpa_pkg::job_type front_job;
   logic queue_valid;
   logic queue_pop;
   rpa_pkg::job_type queue_job;

   rpa_front #(
      .NUM_PAGES(NUM_PAGES)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .clearing(clearing),
      .job_valid(front_valid),
      .job_ready(front_ready),
      .job(front_job)
   );

   rpa_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push_valid(front_valid),
      .push_ready(front_ready),
      .push_job(front_job),
      .pop_valid(queue_valid),
      .pop(queue_pop),
      .pop_job(queue_job)
   );

   rpa_back #(
      .NUM_PAGES(NUM_PAGES)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .job_valid(queue_valid),
      .job(queue_job),
      .job_pop(queue_pop),
      .clearing(clearing),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data)
   );

endmodule

/* rtl/rpa_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Standalone; used for the free stack and the reference count table.
module rpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic clock,
   input  logic wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/rpa_front.sv */
// Front end: takes requests, checks free addresses against the bound registers
// and reduces the page number to a table index. Depends on rpa_pkg.
module rpa_front #(
   parameter int NUM_PAGES = rpa_pkg::NUM_PAGES_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  rpa_pkg::req_type req_data,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic csr_index,
   input  logic [rpa_pkg::ADDR_BITS-1:0] csr_wdata,
   input  logic clearing,
   output logic job_valid,
   input  logic job_ready,
   output rpa_pkg::job_type job
);

   localparam int PN_BITS = rpa_pkg::PN_BITS;
   localparam int IDX_BITS = $clog2(NUM_PAGES);
   localparam int MOD_SHIFT = PN_BITS + IDX_BITS;
   localparam int MUL_BITS = PN_BITS + 2;
   localparam int PROD_BITS = PN_BITS + MUL_BITS;
   localparam int QN_BITS = PN_BITS + IDX_BITS + 2;
   localparam logic [63:0] MOD_MUL_WIDE = (64'd1 << MOD_SHIFT) / 64'(NUM_PAGES);
   localparam logic [MUL_BITS-1:0] MOD_MUL = MOD_MUL_WIDE[MUL_BITS-1:0];

   logic [rpa_pkg::ADDR_BITS-1:0] kernel_end_ff, kernel_end_in;
   logic [rpa_pkg::ADDR_BITS-1:0] phys_top_ff, phys_top_in;

   logic a_valid_ff, a_valid_in;
   logic [1:0] a_action_ff;
   logic a_bad_ff, a_bad_in;
   logic [PN_BITS-1:0] a_pn_ff, a_pn_in;
   logic [PROD_BITS-1:0] a_prod_ff, a_prod_in;

   logic b_valid_ff, b_valid_in;
   logic [1:0] b_action_ff;
   logic b_bad_ff;
   logic [PN_BITS-1:0] b_pn_ff;
   logic [PN_BITS-1:0] b_qn_ff;

   logic advance;
   logic accept;
   logic [PROD_BITS-MOD_SHIFT-1:0] q_est;
   logic [QN_BITS-1:0] qn_full;
   logic [PN_BITS:0] rem;
   logic [PN_BITS:0] rem_fix;

   assign csr_ready = 1'b1;

   always_comb begin
      kernel_end_in = kernel_end_ff;
      phys_top_in = phys_top_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            rpa_pkg::CSR_KERNEL_END: kernel_end_in = csr_wdata;
            rpa_pkg::CSR_PHYS_TOP: phys_top_in = csr_wdata;
         endcase
      end
   end

   assign advance = !b_valid_ff || job_ready;
   assign req_stall = !advance || clearing;
   assign accept = req_valid && !req_stall;

   assign a_valid_in = accept;
   assign a_pn_in = req_data.page_addr[rpa_pkg::ADDR_BITS-1:rpa_pkg::PAGE_SHIFT];
   assign a_bad_in = (req_data.page_addr[rpa_pkg::PAGE_SHIFT-1:0] != '0)
                     || (req_data.page_addr < kernel_end_ff)
                     || (req_data.page_addr >= phys_top_ff);
   assign a_prod_in = PROD_BITS'(a_pn_in) * PROD_BITS'(MOD_MUL);

   assign q_est = a_prod_ff[PROD_BITS-1:MOD_SHIFT];
   assign qn_full = QN_BITS'(q_est) * QN_BITS'(NUM_PAGES);
   assign b_valid_in = a_valid_ff;

   assign rem = {1'b0, b_pn_ff} - {1'b0, b_qn_ff};
   assign rem_fix = (rem >= (PN_BITS + 1)'(NUM_PAGES)) ? rem - (PN_BITS + 1)'(NUM_PAGES) : rem;

   assign job_valid = b_valid_ff;
   assign job.action = b_action_ff;
   assign job.bad = b_bad_ff;
   assign job.pn = b_pn_ff;
   assign job.idx = rem_fix[PN_BITS-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         kernel_end_ff <= 32'h8000_0000;
         phys_top_ff <= 32'h8800_0000;
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         kernel_end_ff <= kernel_end_in;
         phys_top_ff <= phys_top_in;
         if (advance) begin
            a_valid_ff <= a_valid_in;
            b_valid_ff <= b_valid_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_action_ff <= req_data.action;
         a_bad_ff <= a_bad_in;
         a_pn_ff <= a_pn_in;
         a_prod_ff <= a_prod_in;
         b_action_ff <= a_action_ff;
         b_bad_ff <= a_bad_ff;
         b_pn_ff <= a_pn_ff;
         b_qn_ff <= qn_full[PN_BITS-1:0];
      end
   end

endmodule

/* rtl/rpa_queue.sv */
// Short FIFO of classified jobs between the front end and the back end.
// Depends on rpa_pkg for the job type and the depth.
module rpa_queue (
   input  logic clock,
   input  logic reset,
   input  logic push_valid,
   output logic push_ready,
   input  rpa_pkg::job_type push_job,
   output logic pop_valid,
   input  logic pop,
   output rpa_pkg::job_type pop_job
);

   localparam int PTR_BITS = $clog2(rpa_pkg::QUEUE_DEPTH);

   rpa_pkg::job_type slot_ff [rpa_pkg::QUEUE_DEPTH];
   logic [PTR_BITS:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS:0] rd_ptr_ff, rd_ptr_in;
   logic do_push;
   logic do_pop;
   logic empty;
   logic full;

   assign empty = (wr_ptr_ff == rd_ptr_ff);
   assign full = (wr_ptr_ff[PTR_BITS] != rd_ptr_ff[PTR_BITS])
                 && (wr_ptr_ff[PTR_BITS-1:0] == rd_ptr_ff[PTR_BITS-1:0]);
   assign push_ready = !full;
   assign pop_valid = !empty;
   assign pop_job = slot_ff[rd_ptr_ff[PTR_BITS-1:0]];
   assign do_push = push_valid && push_ready;
   assign do_pop = pop && pop_valid;
   assign wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
   assign rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff[PTR_BITS-1:0]] <= push_job;
      end
   end

endmodule

/* rtl/rpa_back.sv */
// Back end: free stack, reference count table, clearing pass and result register.
// Depends on rpa_pkg, rpa_ram and the assertion macro header.
`include "refcounted_page_allocator_top_macros.svh"

module rpa_back #(
   parameter int NUM_PAGES = rpa_pkg::NUM_PAGES_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic job_valid,
   input  rpa_pkg::job_type job,
   output logic job_pop,
   output logic clearing,
   output logic rsp_valid,
   input  logic rsp_stall,
   output rpa_pkg::rsp_type rsp_data
);

   localparam int PN_BITS = rpa_pkg::PN_BITS;
   localparam int CNT_BITS = rpa_pkg::CNT_BITS;
   localparam int IDX_BITS = $clog2(NUM_PAGES);
   localparam int DEPTH_BITS = $clog2(NUM_PAGES + 1);
   localparam int STK_BITS = PN_BITS + IDX_BITS;

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE = 2'd1;
   localparam logic [1:0] ST_EXEC = 2'd2;

   logic [1:0] state_ff, state_in;
   logic [IDX_BITS-1:0] clr_ff, clr_in;
   logic [DEPTH_BITS-1:0] depth_ff, depth_in;
   logic [DEPTH_BITS-1:0] depth_dec;
   rpa_pkg::job_type cur_ff, cur_in;
   logic rsp_valid_ff, rsp_valid_in;
   rpa_pkg::rsp_type rsp_ff, rsp_in;
   logic out_ready;

   logic cnt_wr_en;
   logic [IDX_BITS-1:0] cnt_wr_addr;
   logic [CNT_BITS-1:0] cnt_wr_data;
   logic cnt_rd_en;
   logic [IDX_BITS-1:0] cnt_rd_addr;
   logic [CNT_BITS-1:0] cnt_rd_data;
   logic [CNT_BITS-1:0] cnt_dec;
   logic [CNT_BITS-1:0] cnt_inc;

   logic stk_wr_en;
   logic [IDX_BITS-1:0] stk_wr_addr;
   logic [STK_BITS-1:0] stk_wr_data;
   logic stk_rd_en;
   logic [IDX_BITS-1:0] stk_rd_addr;
   logic [STK_BITS-1:0] stk_rd_data;
   logic [PN_BITS-1:0] stk_pn;
   logic [IDX_BITS-1:0] stk_idx;

   rpa_ram #(
      .WIDTH(CNT_BITS),
      .DEPTH(NUM_PAGES)
   ) u_cnt_ram (
      .clock(clock),
      .wr_en(cnt_wr_en),
      .wr_addr(cnt_wr_addr),
      .wr_data(cnt_wr_data),
      .rd_en(cnt_rd_en),
      .rd_addr(cnt_rd_addr),
      .rd_data(cnt_rd_data)
   );

   rpa_ram #(
      .WIDTH(STK_BITS),
      .DEPTH(NUM_PAGES)
   ) u_stk_ram (
      .clock(clock),
      .wr_en(stk_wr_en),
      .wr_addr(stk_wr_addr),
      .wr_data(stk_wr_data),
      .rd_en(stk_rd_en),
      .rd_addr(stk_rd_addr),
      .rd_data(stk_rd_data)
   );

   assign stk_pn = stk_rd_data[STK_BITS-1:IDX_BITS];
   assign stk_idx = stk_rd_data[IDX_BITS-1:0];
   assign depth_dec = depth_ff - 1'b1;
   assign cnt_dec = (cnt_rd_data == '0) ? '0 : cnt_rd_data - 1'b1;
   assign cnt_inc = (cnt_rd_data == rpa_pkg::CNT_MAX) ? rpa_pkg::CNT_MAX : cnt_rd_data + 1'b1;
   assign out_ready = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      clr_in = clr_ff;
      depth_in = depth_ff;
      cur_in = cur_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in = rsp_ff;
      job_pop = 1'b0;
      cnt_wr_en = 1'b0;
      cnt_wr_addr = cur_ff.idx[IDX_BITS-1:0];
      cnt_wr_data = '0;
      cnt_rd_en = 1'b0;
      cnt_rd_addr = job.idx[IDX_BITS-1:0];
      stk_wr_en = 1'b0;
      stk_wr_addr = depth_ff[IDX_BITS-1:0];
      stk_wr_data = {cur_ff.pn, cur_ff.idx[IDX_BITS-1:0]};
      stk_rd_en = 1'b0;
      stk_rd_addr = depth_dec[IDX_BITS-1:0];
      unique case (state_ff)
         ST_CLEAR: begin
            cnt_wr_en = 1'b1;
            cnt_wr_addr = clr_ff;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == IDX_BITS'(NUM_PAGES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (job_valid) begin
               job_pop = 1'b1;
               cur_in = job;
               cnt_rd_en = 1'b1;
               stk_rd_en = (job.action == rpa_pkg::ACT_ALLOC) && (depth_ff != '0);
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (out_ready) begin
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
               rsp_in.status = rpa_pkg::STAT_OK;
               rsp_in.alloc_addr = '0;
               rsp_in.ref_count = '0;
               unique case (cur_ff.action)
                  rpa_pkg::ACT_ALLOC: begin
                     if (depth_ff == '0) begin
                        rsp_in.status = rpa_pkg::STAT_NO_FREE;
                     end else begin
                        depth_in = depth_dec;
                        rsp_in.alloc_addr = {stk_pn, {rpa_pkg::PAGE_SHIFT{1'b0}}};
                        rsp_in.ref_count = rpa_pkg::CNT_ONE;
                        cnt_wr_en = 1'b1;
                        cnt_wr_addr = stk_idx;
                        cnt_wr_data = rpa_pkg::CNT_ONE;
                     end
                  end
                  rpa_pkg::ACT_FREE: begin
                     if (cur_ff.bad) begin
                        rsp_in.status = rpa_pkg::STAT_BAD_ADDR;
                     end else begin
                        cnt_wr_en = 1'b1;
                        cnt_wr_data = cnt_dec;
                        rsp_in.ref_count = cnt_dec;
                        if (cnt_dec == '0) begin
                           if (depth_ff == DEPTH_BITS'(NUM_PAGES)) begin
                              rsp_in.status = rpa_pkg::STAT_STACK_FULL;
                           end else begin
                              stk_wr_en = 1'b1;
                              depth_in = depth_ff + 1'b1;
                           end
                        end
                     end
                  end
                  rpa_pkg::ACT_ADD_REF: begin
                     cnt_wr_en = 1'b1;
                     cnt_wr_data = cnt_inc;
                     rsp_in.ref_count = cnt_inc;
                  end
                  rpa_pkg::ACT_QUERY: begin
                     rsp_in.ref_count = cnt_rd_data;
                  end
               endcase
               rsp_in.free_pages = rpa_pkg::FREE_BITS'(depth_in);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff <= '0;
         depth_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         depth_ff <= depth_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      rsp_ff <= rsp_in;
   end

   assign clearing = (state_ff == ST_CLEAR);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   `RPA_ASSERT_SAME(a_depth_bound, clock, reset, 1'b1, depth_ff <= DEPTH_BITS'(NUM_PAGES),
      "free stack depth exceeds the page count")
   `RPA_ASSERT_SAME(a_stack_ports, clock, reset, stk_wr_en, !stk_rd_en,
      "free stack pushed and popped in the same cycle")
   `RPA_ASSERT_SAME(a_no_pop_busy, clock, reset, job_pop, state_ff == ST_IDLE,
      "job taken while the back end is clearing or busy")
   `RPA_ASSERT_NEXT(a_exec_result, clock, reset, (state_ff == ST_EXEC) && out_ready,
      rsp_valid_ff && (state_ff == ST_IDLE), "finished job produced no result")

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps
// Self-checking testbench for refcounted_page_allocator_top: named tests drive
// transactions that a predictor in this file checks. Depends on rpa_pkg and the RTL.
module testbench;
   import rpa_pkg::*;

   localparam int PAGES = NUM_PAGES_DEFAULT;
   localparam int IDX_BITS = $clog2(PAGES);
   localparam int CYCLE_LIMIT = 3000000;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   req_type req_data;
   logic rsp_valid;
   logic rsp_stall;
   rsp_type rsp_data;
   logic csr_valid;
   logic csr_ready;
   logic csr_index;
   logic [ADDR_BITS-1:0] csr_wdata;

   logic [CNT_BITS-1:0] page_counts [PAGES];
   logic [PN_BITS-1:0] free_page_stack [PAGES];
   int stack_level;
   logic [ADDR_BITS-1:0] kernel_end_q;
   logic [ADDR_BITS-1:0] phys_top_q;

   rsp_type pending_rsps [$];
   logic [ADDR_BITS-1:0] held_pages [$];
   int idle_levels [4] = '{0, 10, 30, 60};
   int gap_pct;
   int stall_pct;
   int hold_len;
   int items_sent;
   int rsp_seen;
   int settings_done;
   int mismatches;
   int cycles;

   refcounted_page_allocator_top u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic rsp_type predict_allocation(req_type item);
      rsp_type res;
      logic [IDX_BITS-1:0] slot;
      logic [PN_BITS-1:0] pn;
      res = '0;
      slot = item.page_addr[PAGE_SHIFT +: IDX_BITS];
      case (item.action)
         ACT_ALLOC: begin
            if (stack_level == 0) begin
               res.status = STAT_NO_FREE;
            end else begin
               stack_level = stack_level - 1;
               pn = free_page_stack[stack_level];
               res.alloc_addr = {pn, {PAGE_SHIFT{1'b0}}};
               page_counts[pn[IDX_BITS-1:0]] = CNT_ONE;
               res.ref_count = CNT_ONE;
            end
         end
         ACT_FREE: begin
            if (item.page_addr[PAGE_SHIFT-1:0] != '0 || item.page_addr < kernel_end_q ||
                item.page_addr >= phys_top_q) begin
               res.status = STAT_BAD_ADDR;
            end else begin
               if (page_counts[slot] != '0) page_counts[slot] = page_counts[slot] - 1'b1;
               res.ref_count = page_counts[slot];
               if (res.ref_count == '0) begin
                  if (stack_level >= PAGES) begin
                     res.status = STAT_STACK_FULL;
                  end else begin
                     free_page_stack[stack_level] = item.page_addr[ADDR_BITS-1:PAGE_SHIFT];
                     stack_level = stack_level + 1;
                  end
               end
            end
         end
         ACT_ADD_REF: begin
            if (page_counts[slot] != CNT_MAX) page_counts[slot] = page_counts[slot] + 1'b1;
            res.ref_count = page_counts[slot];
         end
         ACT_QUERY: begin
            res.ref_count = page_counts[slot];
         end
      endcase
      res.free_pages = stack_level[FREE_BITS-1:0];
      return res;
   endfunction

   task automatic report_mismatch(input string field, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatches++;
      if (mismatches <= 50)
         $display("mismatch: result %0d %s got 0x%0h expected 0x%0h", rsp_seen, field, got, want);
   endtask

   task automatic send_request(input logic [1:0] action, input logic [ADDR_BITS-1:0] addr);
      req_type item;
      rsp_type want;
      item.action = action;
      item.page_addr = addr;
      if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (req_stall);
      want = predict_allocation(item);
      pending_rsps.push_back(want);
      if (action == ACT_ALLOC && want.status == STAT_OK) held_pages.push_back(want.alloc_addr);
      items_sent++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_rsps.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic configure(input logic [ADDR_BITS-1:0] kend, input logic [ADDR_BITS-1:0] ptop);
      csr_valid <= 1'b1;
      csr_index <= CSR_KERNEL_END;
      csr_wdata <= kend;
      do @(posedge clock); while (!csr_ready);
      kernel_end_q = kend;
      csr_index <= CSR_PHYS_TOP;
      csr_wdata <= ptop;
      do @(posedge clock); while (!csr_ready);
      phys_top_q = ptop;
      csr_valid <= 1'b0;
      settings_done++;
   endtask

   task automatic test_directed();
      gap_pct = 20;
      stall_pct = 20;
      send_request(ACT_ALLOC, 32'h0000_0000);
      send_request(ACT_QUERY, 32'h0000_0000);
      send_request(ACT_ADD_REF, 32'hFFFF_FFFF);
      send_request(ACT_QUERY, 32'h87FF_F000);
      send_request(ACT_FREE, 32'h8000_0001);
      send_request(ACT_FREE, 32'h7FFF_F000);
      send_request(ACT_FREE, 32'h8800_0000);
      send_request(ACT_FREE, 32'hFFFF_F000);
      send_request(ACT_FREE, 32'h8000_0000);
      send_request(ACT_FREE, 32'h87FF_F000);
      send_request(ACT_FREE, 32'h8000_0000);
      send_request(ACT_ALLOC, 32'hFFFF_FFFF);
      send_request(ACT_ADD_REF, 32'h8000_0000);
      send_request(ACT_QUERY, 32'h8000_0000);
      send_request(ACT_FREE, 32'h8000_0000);
      send_request(ACT_FREE, 32'h8000_0000);
      repeat (4) send_request(ACT_ALLOC, 32'h0000_0000);
      wait_drained();
   endtask

   task automatic test_count_saturation();
      gap_pct = 10;
      stall_pct = 10;
      repeat (260) send_request(ACT_ADD_REF, 32'h8000_1000);
      send_request(ACT_QUERY, 32'h8000_1000);
      send_request(ACT_FREE, 32'h8000_1000);
      send_request(ACT_QUERY, 32'h8000_1000);
      wait_drained();
   endtask

   task automatic test_register_extremes();
      gap_pct = 0;
      stall_pct = 30;
      configure(32'h0000_0000, 32'hFFFF_FFFF);
      send_request(ACT_FREE, 32'h0000_0000);
      send_request(ACT_FREE, 32'hFFFF_F000);
      send_request(ACT_FREE, 32'hFFFF_FFFF);
      repeat (3) send_request(ACT_ALLOC, 32'h0000_0000);
      wait_drained();
      configure(32'hFFFF_FFFF, 32'h0000_0000);
      send_request(ACT_FREE, 32'h0000_0000);
      send_request(ACT_FREE, 32'hFFFF_F000);
      send_request(ACT_ADD_REF, 32'h0000_0000);
      send_request(ACT_QUERY, 32'h0000_0000);
      wait_drained();
      configure(32'h4000_0000, 32'h4000_0000);
      send_request(ACT_FREE, 32'h4000_0000);
      send_request(ACT_FREE, 32'h3FFF_F000);
      wait_drained();
   endtask

   task automatic run_random_phase(input logic [ADDR_BITS-1:0] kend,
                                   input logic [ADDR_BITS-1:0] ptop,
                                   input int npages, input int count);
      logic [ADDR_BITS-1:0] addr;
      int pick;
      int sel;
      configure(kend, ptop);
      held_pages.delete();
      for (int i = 0; i < npages; i++) send_request(ACT_FREE, kend + (i << PAGE_SHIFT));
      for (int i = 0; i < count; i++) begin
         if (i % 100 == 0) begin
            gap_pct = idle_levels[$urandom_range(0, 3)];
            stall_pct = idle_levels[$urandom_range(0, 3)];
         end
         pick = $urandom_range(0, 99);
         addr = kend + ($urandom_range(0, npages - 1) << PAGE_SHIFT);
         if (held_pages.size() != 0 && $urandom_range(0, 3) != 0) begin
            sel = $urandom_range(0, held_pages.size() - 1);
            if (pick >= 30 && pick < 55) begin
               addr = held_pages[sel];
               held_pages.delete(sel);
            end else if (pick >= 55 && pick < 70) begin
               addr = held_pages[sel];
            end
         end
         if (pick < 30) begin
            send_request(ACT_ALLOC, $urandom());
         end else if (pick < 55) begin
            send_request(ACT_FREE, addr);
         end else if (pick < 70) begin
            send_request(ACT_ADD_REF, addr);
         end else if (pick < 85) begin
            send_request(ACT_QUERY, addr);
         end else if (pick < 92) begin
            case ($urandom_range(0, 2))
               0: send_request(ACT_FREE, addr | $urandom_range(1, 4095));
               1: send_request(ACT_FREE, kend - 32'h1000);
               default: send_request(ACT_FREE, ptop);
            endcase
         end else begin
            send_request(2'($urandom_range(0, 3)), $urandom());
         end
      end
      wait_drained();
   endtask

   task automatic test_random_traffic();
      run_random_phase(32'h8000_0000, 32'h8002_8000, 40, 420);
      run_random_phase(32'hFFFD_0000, 32'hFFFF_FFFF, 48, 380);
      run_random_phase(32'h0000_0000, 32'h0002_0000, 32, 320);
   endtask

   task automatic test_backpressure();
      gap_pct = 0;
      stall_pct = 0;
      hold_len = 400;
      for (int i = 0; i < 60; i++) begin
         if (i % 3 == 0) send_request(ACT_ALLOC, 32'h0000_0000);
         else if (i % 3 == 1) send_request(ACT_FREE, 32'h0000_1000 * i);
         else send_request(ACT_QUERY, 32'h0000_1000 * i);
      end
      wait_drained();
   endtask

   task automatic test_double_free();
      logic [ADDR_BITS-1:0] page;
      gap_pct = 0;
      stall_pct = 0;
      page = 32'h0001_0000;
      configure(32'h0000_0000, 32'hFFFF_FFFF);
      repeat (40) send_request(ACT_FREE, page);
      send_request(ACT_FREE, 32'h0002_0000);
      repeat (3) send_request(ACT_ALLOC, 32'h0000_0000);
      send_request(ACT_FREE, page);
      send_request(ACT_QUERY, page);
      wait_drained();
   endtask

   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_len != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold_len) @(posedge clock);
            hold_len = 0;
            rsp_stall <= 1'b0;
         end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      rsp_type got;
      rsp_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            got = rsp_data;
            if (pending_rsps.size() == 0) begin
               report_mismatch("unexpected result, free_pages", 32'(got.free_pages), '0);
            end else begin
               want = pending_rsps.pop_front();
               if (got.status !== want.status)
                  report_mismatch("status", 32'(got.status), 32'(want.status));
               if (got.alloc_addr !== want.alloc_addr)
                  report_mismatch("alloc_addr", got.alloc_addr, want.alloc_addr);
               if (got.ref_count !== want.ref_count)
                  report_mismatch("ref_count", 32'(got.ref_count), 32'(want.ref_count));
               if (got.free_pages !== want.free_pages)
                  report_mismatch("free_pages", 32'(got.free_pages), 32'(want.free_pages));
            end
            rsp_seen++;
         end
      end
   end

   initial begin
      cycles = 0;
      while (cycles <= CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("tb: failure");
      $finish;
   end

   initial begin
      foreach (page_counts[i]) page_counts[i] = '0;
      stack_level = 0;
      kernel_end_q = 32'h8000_0000;
      phys_top_q = 32'h8800_0000;
      gap_pct = 0;
      stall_pct = 0;
      hold_len = 0;
      items_sent = 0;
      rsp_seen = 0;
      settings_done = 0;
      mismatches = 0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      csr_valid <= 1'b0;
      csr_index <= CSR_KERNEL_END;
      csr_wdata <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_count_saturation();
      test_register_extremes();
      test_random_traffic();
      test_backpressure();
      test_double_free();
      if (pending_rsps.size() != 0)
         report_mismatch("results never returned", 32'(pending_rsps.size()), '0);
      $display("tb: %0d requests sent, %0d results checked, %0d register settings, %0d mismatches",
               items_sent, rsp_seen, settings_done, mismatches);
      $display("tb: covered empty stack, double frees, rejected frees, saturation, aliasing, long hold");
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
